[hw/rtl/rv64_subset_execute_unit_macros.svh]
// assertion macros shared by the rtl of the rv64 subset execute unit
// no dependencies; each macro is empty when SYNTHESIS is defined
`ifndef RV64_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define RV64_SUBSET_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every edge outside reset
`define RSE_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSE_ASSERT_RST(label, clk, rst_n, prop, msg)
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/rv64se_pkg.sv]
// types, codes and helper functions of the rv64 subset execute unit
// no dependencies; used by the interfaces and the top level
`timescale 1ns / 1ps

package rv64se_pkg;

    localparam int XLEN       = 64;
    localparam int NREGS      = 32;
    localparam int RIDX_W     = $clog2(NREGS);
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 16;
    // word count must be a power of two up to 2**IDX_W; slots are the low index bits
    localparam int MEM_WORDS  = 65536;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_PW + 1;

    localparam logic       ACT_EXEC    = 1'b0;
    localparam logic       ACT_PRELOAD = 1'b1;

    localparam logic [2:0] KIND_I = 3'd0;
    localparam logic [2:0] KIND_R = 3'd1;
    localparam logic [2:0] KIND_S = 3'd2;
    localparam logic [2:0] KIND_J = 3'd3;

    // funct3 of an I item: zero is addi, anything else is ld
    localparam logic [2:0] F3_ADDI = 3'd0;
    // funct7 of an R item: zero is add, anything else is sub
    localparam logic [6:0] F7_ADD  = 7'd0;

    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } t_phase;

    typedef struct packed {
        logic              action;
        logic [2:0]        kind;
        logic [2:0]        op_minor;
        logic [6:0]        op_major;
        logic [4:0]        dest_reg;
        logic [4:0]        src_a;
        logic [4:0]        src_b;
        logic [20:0]       imm_raw;
        logic [15:0]       preload_index;
        logic [31:0]       preload_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0]       next_pc;
        logic              dest_written;
        logic [4:0]        dest_index;
        logic [63:0]       dest_value;
        logic              store_done;
    } t_out_item;

    function automatic logic [XLEN-1:0] sext12(input logic [20:0] imm);
        return {{(XLEN-12){imm[11]}}, imm[11:0]};
    endfunction

    function automatic logic [XLEN-1:0] sext13(input logic [20:0] imm);
        return {{(XLEN-13){imm[12]}}, imm[12:0]};
    endfunction

    function automatic logic [XLEN-1:0] sext21(input logic [20:0] imm);
        return {{(XLEN-21){imm[20]}}, imm[20:0]};
    endfunction

    // quotient by four rounded toward zero, low index bits only
    function automatic logic [IDX_W-1:0] word_index(input logic [XLEN-1:0] addr);
        logic round_up;
        round_up = addr[XLEN-1] & (|addr[1:0]);
        return addr[IDX_W+1:2] + IDX_W'(round_up);
    endfunction

endpackage

[hw/rtl/rv64se_ifs.sv]
// valid/ready channel interfaces for the instruction and result items
// depends on rv64se_pkg for the payload types
`timescale 1ns / 1ps

interface rv64se_in_if;
    logic                 valid;
    logic                 ready;
    rv64se_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rv64se_out_if;
    logic                  valid;
    logic                  ready;
    rv64se_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rv64se_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read returns the old contents on a same-address write
`timescale 1ns / 1ps

module rv64se_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rv64_subset_execute_unit.sv]
// channel   | dir | payload                     | handshake
// i_in      | in  | rv64se_pkg::t_in_item       | valid/ready, taken when both high
// o_out     | out | rv64se_pkg::t_out_item      | valid/ready, taken when both high
//
// no item is accepted while the execute stage holds one; the single word-memory port sets this, since
// ld and sd touch two words (first word in the execute stage, second in the next).
// a result passes the execute, second memory and writeback stages, then enters the output queue.
// after reset the word memory is swept to zero, one word a cycle, all 65536 words, with
// no item accepted meanwhile. register file reset uses 32 valid bits.
// a 4-entry result queue absorbs output stalls; input stalls once it would fill.
// depends on rv64se_pkg, rv64se_ifs, rv64se_ram and the assertion macro header
`timescale 1ns / 1ps
`include "rv64_subset_execute_unit_macros.svh"

module rv64_subset_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rv64se_in_if.sink     i_in,
    rv64se_out_if.source  o_out
);

    import rv64se_pkg::*;

    // clear sweep
    t_phase              r_phase;
    t_phase              n_phase;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic                w_clearing;

    logic                w_acc;
    logic [FIFO_CW:0]    w_busy;

    // execute stage
    logic                r_s1_v;
    t_in_item            r_s1;
    logic [XLEN-1:0]     r_pc;
    logic [XLEN-1:0]     w_ram_a;
    logic [XLEN-1:0]     w_ram_b;
    logic [XLEN-1:0]     w_a;
    logic [XLEN-1:0]     w_b;
    logic [XLEN-1:0]     w_imm12;
    logic [XLEN-1:0]     w_addr;
    logic [IDX_W-1:0]    w_i1;
    logic [XLEN-1:0]     w_sum;
    logic [XLEN-1:0]     w_pc4;
    logic [XLEN-1:0]     w_pc_tgt;
    logic                w_take;
    logic [XLEN-1:0]     n_next_pc;
    logic                n_wr;
    logic [XLEN-1:0]     n_val;
    logic                n_st;
    logic                n_ld;
    logic                n_sd;
    logic                n_pre;

    // second memory stage
    logic                r_s2_v;
    logic [XLEN-1:0]     r_s2_pc;
    logic                r_s2_wr;
    logic [RIDX_W-1:0]   r_s2_rd;
    logic [XLEN-1:0]     r_s2_val;
    logic                r_s2_st;
    logic                r_s2_ld;
    logic                r_s2_sd;
    logic [IDX_W-1:0]    r_s2_i2;
    logic [WORD_W-1:0]   r_s2_lo;

    // writeback stage
    logic                r_s3_v;
    logic [XLEN-1:0]     r_s3_pc;
    logic                r_s3_wr;
    logic [RIDX_W-1:0]   r_s3_rd;
    logic [XLEN-1:0]     r_s3_val;
    logic                r_s3_st;
    logic                r_s3_ld;
    logic [WORD_W-1:0]   r_s3_hi;
    logic                w_wb_en;
    logic [XLEN-1:0]     w_wb_val;

    // last writeback, not yet visible at the ram read port
    logic                r_wb_v;
    logic [RIDX_W-1:0]   r_wb_idx;
    logic [XLEN-1:0]     r_wb_val;
    logic [NREGS-1:0]    r_rvalid;

    // word memory port
    logic                w_mem_we;
    logic [MEM_AW-1:0]   w_mem_waddr;
    logic [WORD_W-1:0]   w_mem_wdata;
    logic [MEM_AW-1:0]   w_mem_raddr;
    logic [WORD_W-1:0]   w_mem_rdata;

    // result queue
    t_out_item           r_fifo [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  r_wp;
    logic [FIFO_PW-1:0]  r_rp;
    logic [FIFO_CW-1:0]  r_cnt;
    logic                w_push;
    logic                w_pop;
    t_out_item           w_res;

    // ---------------------------------------------------------------- clear fsm
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_CLEAR: begin
                if (r_clr_addr == {MEM_AW{1'b1}}) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                n_phase = PH_RUN;
            end
            default: begin
                n_phase = PH_CLEAR;
            end
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_CLEAR: w_clearing = 1'b1;
            PH_RUN:   w_clearing = 1'b0;
            default:  w_clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------- accept
    // items still to land in the queue must fit, counting the new one
    assign w_busy = (FIFO_CW+1)'(r_cnt) + (FIFO_CW+1)'(r_s2_v) + (FIFO_CW+1)'(r_s3_v);
    assign i_in.ready = !w_clearing && !r_s1_v && (w_busy < (FIFO_CW+1)'(FIFO_DEPTH));
    assign w_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= i_in.data;
        end
    end

    // ---------------------------------------------------------------- register file
    rv64se_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_wb_en),
        .i_waddr (r_s3_rd),
        .i_wdata (w_wb_val),
        .i_raddr (i_in.data.src_a),
        .o_rdata (w_ram_a)
    );

    rv64se_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_wb_en),
        .i_waddr (r_s3_rd),
        .i_wdata (w_wb_val),
        .i_raddr (i_in.data.src_b),
        .o_rdata (w_ram_b)
    );

    // forward the writeback of this cycle, then that of the cycle before
    always_comb begin
        if (w_wb_en && r_s3_rd == r_s1.src_a) begin
            w_a = w_wb_val;
        end else if (r_wb_v && r_wb_idx == r_s1.src_a) begin
            w_a = r_wb_val;
        end else if (r_rvalid[r_s1.src_a]) begin
            w_a = w_ram_a;
        end else begin
            w_a = '0;
        end
        if (w_wb_en && r_s3_rd == r_s1.src_b) begin
            w_b = w_wb_val;
        end else if (r_wb_v && r_wb_idx == r_s1.src_b) begin
            w_b = r_wb_val;
        end else if (r_rvalid[r_s1.src_b]) begin
            w_b = w_ram_b;
        end else begin
            w_b = '0;
        end
    end

    // ---------------------------------------------------------------- execute
    assign w_imm12  = sext12(r_s1.imm_raw);
    assign w_addr   = w_a + w_imm12;
    assign w_i1     = word_index(w_addr);
    assign w_sum    = (r_s1.op_major != F7_ADD) ? (w_a - w_b) : (w_a + w_b);
    assign w_pc4    = r_pc + XLEN'(4);
    assign w_pc_tgt = r_pc + ((r_s1.kind == KIND_J) ? sext21(r_s1.imm_raw)
                                                    : sext13(r_s1.imm_raw));

    always_comb begin
        unique case (r_s1.op_minor)
            F3_BEQ:  w_take = (w_a == w_b);
            F3_BNE:  w_take = (w_a != w_b);
            F3_BLT:  w_take = ($signed(w_a) < $signed(w_b));
            F3_BGE:  w_take = !($signed(w_a) < $signed(w_b));
            default: w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_next_pc = w_pc4;
        n_wr      = 1'b0;
        n_val     = w_addr;
        n_st      = 1'b0;
        n_ld      = 1'b0;
        n_sd      = 1'b0;
        n_pre     = 1'b0;
        if (r_s1.action == ACT_PRELOAD) begin
            n_next_pc = r_pc;
            n_st      = 1'b1;
            n_pre     = 1'b1;
        end else begin
            unique case (r_s1.kind)
                KIND_I: begin
                    n_wr = 1'b1;
                    n_ld = (r_s1.op_minor != F3_ADDI);
                end
                KIND_R: begin
                    n_wr  = 1'b1;
                    n_val = w_sum;
                end
                KIND_S: begin
                    n_sd = 1'b1;
                    n_st = 1'b1;
                end
                KIND_J: begin
                    n_wr      = 1'b1;
                    n_val     = w_pc4;
                    n_next_pc = w_pc_tgt;
                end
                // branch, and the unused kinds that behave as branches
                default: begin
                    if (w_take) begin
                        n_next_pc = w_pc_tgt;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_s1_v <= w_acc;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (r_s1_v) begin
                r_pc <= n_next_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_pc  <= n_next_pc;
        r_s2_wr  <= n_wr && (r_s1.dest_reg != '0);
        r_s2_rd  <= r_s1.dest_reg;
        r_s2_val <= n_val;
        r_s2_st  <= n_st;
        r_s2_ld  <= n_ld;
        r_s2_sd  <= n_sd;
        r_s2_i2  <= w_i1 + IDX_W'(1);
        r_s2_lo  <= w_b[WORD_W-1:0];

        r_s3_pc  <= r_s2_pc;
        r_s3_wr  <= r_s2_wr;
        r_s3_rd  <= r_s2_rd;
        r_s3_val <= r_s2_val;
        r_s3_st  <= r_s2_st;
        r_s3_ld  <= r_s2_ld;
        r_s3_hi  <= w_mem_rdata;
    end

    // ---------------------------------------------------------------- word memory
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_i1[MEM_AW-1:0];
        w_mem_wdata = w_b[XLEN-1:WORD_W];
        if (w_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else if (r_s2_v && r_s2_sd) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_s2_i2[MEM_AW-1:0];
            w_mem_wdata = r_s2_lo;
        end else if (r_s1_v && n_sd) begin
            w_mem_we = 1'b1;
        end else if (r_s1_v && n_pre) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_s1.preload_index[MEM_AW-1:0];
            w_mem_wdata = r_s1.preload_word;
        end
        // high word read in execute, low word in the stage after
        w_mem_raddr = (r_s2_v && r_s2_ld) ? r_s2_i2[MEM_AW-1:0] : w_i1[MEM_AW-1:0];
    end

    rv64se_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // ---------------------------------------------------------------- writeback
    assign w_wb_en  = r_s3_v && r_s3_wr;
    assign w_wb_val = r_s3_ld ? {r_s3_hi, w_mem_rdata} : r_s3_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_v   <= 1'b0;
            r_rvalid <= '0;
        end else begin
            r_wb_v <= w_wb_en;
            if (w_wb_en) begin
                r_rvalid[r_s3_rd] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_s3_rd;
        r_wb_val <= w_wb_val;
    end

    // ---------------------------------------------------------------- result queue
    always_comb begin
        w_res.next_pc      = r_s3_pc;
        w_res.dest_written = r_s3_wr;
        w_res.dest_index   = r_s3_wr ? r_s3_rd : '0;
        w_res.dest_value   = r_s3_wr ? w_wb_val : '0;
        w_res.store_done   = r_s3_st;
    end

    assign w_push = r_s3_v;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + FIFO_PW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + FIFO_PW'(1);
            end
            r_cnt <= r_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
        end
    end

    assign o_out.valid = (r_cnt != '0);
    assign o_out.data  = r_fifo[r_rp];

    // ---------------------------------------------------------------- checks
    `RSE_ASSERT_RST(a_no_queue_overflow, i_clk, i_rst_n,
        !w_push || w_pop || (r_cnt != FIFO_CW'(FIFO_DEPTH)), "result queue overflow")
    `RSE_ASSERT_RST(a_port_not_shared, i_clk, i_rst_n,
        !(r_s1_v && r_s2_v), "execute and second memory stage overlap")
    `RSE_ASSERT_RST(a_no_x0_write, i_clk, i_rst_n,
        !w_wb_en || (r_s3_rd != '0), "write to register zero")
    `RSE_ASSERT_NEXT(a_accept_executes, i_clk, i_rst_n,
        w_acc, r_s1_v && !w_clearing, "accepted item did not enter execute")
    `RSE_ASSERT_NEXT(a_exec_reaches_result, i_clk, i_rst_n,
        r_s2_v, r_s3_v && w_push, "item lost between memory and writeback")

endmodule
